// ----- rtl/ist_pkg.sv -----
// ----------------------------------------------------------------------------
// ist_pkg
// Shared types and constants for the integer set table and its cell row.
// ----------------------------------------------------------------------------
package ist_pkg;

  localparam int DEFAULT_CAPACITY = 64;
  localparam int VALUE_W          = 32;
  localparam int POS_W            = 6;
  localparam int COUNT_W          = 7;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_READ   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_DUP    = 2'd1,
    ST_FULL   = 2'd2,
    ST_BADPOS = 2'd3
  } status_e_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e_t;

  // Broadcast from the controller to every cell of the row.
  typedef struct packed {
    logic               capture;  // latch compare and read leaves
    logic               append;   // write value into the first free cell
    logic [POS_W-1:0]   position;
    logic [VALUE_W-1:0] value;
  } cell_ctrl_t;

endpackage

// ----- rtl/ist_cell.sv -----
// ----------------------------------------------------------------------------
// ist_cell
// One slot of the set: holds an entry, compares it against the probe value
// and offers it for a positional read.
// ----------------------------------------------------------------------------
module ist_cell
  import ist_pkg::*;
#(
  parameter int INDEX = 0,
  parameter int CNT_W = 7
) (
  input  logic               clk,
  input  cell_ctrl_t         ctrl,
  input  logic [CNT_W-1:0]   entry_count,
  output logic               hit,
  output logic [VALUE_W-1:0] rd_data
);

  localparam bit POS_REACH = INDEX < (1 << POS_W);

  logic [VALUE_W-1:0] entry;
  logic               occupied;
  logic               selected;

  assign occupied = entry_count > CNT_W'(INDEX);
  assign selected = POS_REACH && (ctrl.position == POS_W'(INDEX)) && occupied;

  // Append lands in the cell whose index equals the current count.
  always_ff @(posedge clk) begin
    if (ctrl.append && (entry_count == CNT_W'(INDEX))) begin
      entry <= ctrl.value;
    end
  end

  // Registered leaves of the match and read trees.
  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      hit     <= occupied && (entry == ctrl.value);
      rd_data <= selected ? entry : '0;
    end
  end

endmodule

// ----- rtl/integer_set_table.sv -----
// ----------------------------------------------------------------------------
// integer_set_table
// Set of distinct 32-bit values in insertion order, held in a row of cells.
// Every cell compares and registers its leaves at the input transfer; execute
// then reduces the leaves and registers the result into the output stage.
// A new item is taken only in idle, once the last one has left execute.
// The next item is taken while a finished result still waits downstream.
// Reset clears the entry count and handshake state; entries stay unwritten
// and are only read below the count, so no clearing pass is run.
// ----------------------------------------------------------------------------
module integer_set_table
  import ist_pkg::*;
#(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                operation,
  input  logic signed [VALUE_W-1:0] value,
  input  logic [POS_W-1:0]          position,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      present,
  output logic signed [VALUE_W-1:0] read_value,
  output logic [1:0]                status,
  output logic [COUNT_W-1:0]        count,
  output logic                      empty_res
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int EXT_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  state_e_t state, state_next;

  // Item held for the execute step.
  op_e_t              op_q;
  logic [VALUE_W-1:0] value_q;
  logic [POS_W-1:0]   pos_q;

  logic [CNT_W-1:0] entry_count, entry_count_next;

  logic in_xfer;
  logic exec_fire;

  cell_ctrl_t         ctrl;
  logic               hit_leaf [CAPACITY];
  logic [VALUE_W-1:0] rd_leaf  [CAPACITY];
  logic               hit_any;
  logic [VALUE_W-1:0] rd_any;

  logic               full;
  logic               do_append;
  logic               present_next;
  logic [VALUE_W-1:0] read_value_next;
  status_e_t          status_next;
  logic [EXT_W-1:0]   count_ext;

  assign in_xfer   = in_valid && !in_stall;
  // Execute only when the result register is free or being emptied now.
  assign exec_fire = (state == S_EXEC) && (!out_valid || !out_stall);

  // --------------------------------------------------------------------------
  // Sequencer: idle takes an item, execute retires it into the output stage.
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_EXEC;
      S_EXEC: if (exec_fire) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state != S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Hold the item for the execute step.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_q    <= op_e_t'(operation);
      value_q <= value;
      pos_q   <= position;
    end
  end

  // --------------------------------------------------------------------------
  // Cell row. The probe value comes straight from the port at the transfer;
  // during execute the held value is broadcast for the append.
  // --------------------------------------------------------------------------
  assign ctrl.capture  = in_xfer;
  assign ctrl.append   = do_append;
  assign ctrl.position = position;
  assign ctrl.value    = in_xfer ? value : value_q;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    ist_cell #(
      .INDEX (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .entry_count (entry_count),
      .hit         (hit_leaf[i]),
      .rd_data     (rd_leaf[i])
    );
  end

  // Reduce the registered leaves; at most one read leaf is non-zero.
  always_comb begin
    hit_any = 1'b0;
    rd_any  = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit_any = hit_any | hit_leaf[i];
      rd_any  = rd_any | rd_leaf[i];
    end
  end

  // --------------------------------------------------------------------------
  // Execute: decide the result and the new count.
  // A duplicate wins over a full set.
  // --------------------------------------------------------------------------
  assign full = (entry_count == CNT_W'(CAPACITY));

  always_comb begin
    present_next     = 1'b0;
    read_value_next  = '1;
    status_next      = ST_OK;
    entry_count_next = entry_count;
    do_append        = 1'b0;
    unique case (op_q)
      OP_INSERT: begin
        if (hit_any) begin
          present_next = 1'b1;
          status_next  = ST_DUP;
        end else if (full) begin
          status_next = ST_FULL;
        end else begin
          do_append        = exec_fire;
          entry_count_next = entry_count + CNT_W'(1);
        end
      end
      OP_LOOKUP: begin
        present_next = hit_any;
      end
      OP_READ: begin
        if (CMP_W'(pos_q) < CMP_W'(entry_count)) begin
          read_value_next = rd_any;
        end else begin
          status_next = ST_BADPOS;
        end
      end
      OP_CLEAR: begin
        entry_count_next = '0;
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (exec_fire) begin
      entry_count <= entry_count_next;
    end
  end

  // --------------------------------------------------------------------------
  // Output stage: parts the row from the consumer.
  // --------------------------------------------------------------------------
  assign count_ext = EXT_W'(entry_count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (exec_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      present    <= present_next;
      read_value <= read_value_next;
      status     <= status_next;
      count      <= count_ext[COUNT_W-1:0];
      empty_res  <= (entry_count_next == '0);
    end
  end

`ifndef SYNTHESIS
  // The count never runs past the row.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  // An accepted item holds off the next one for the execute step.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> in_stall)
    else $error("second item taken while one is in flight");

  // A new result only appears out of the execute step.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_EXEC))
    else $error("result raised without an execute step");

  // A full rejection is only reported against a full row.
  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == ST_FULL)) |-> full)
    else $error("full status with free cells");
`endif

endmodule
